>>> rtl/core/abs_pkg.sv
// Shared types and constants for the alternating-bit sender.
package abs_pkg;

  localparam int MAX_BYTES   = 20;  // payload bytes carried by the ports
  localparam int CHECK_W     = 32;
  localparam int BYTE_SUM_W  = 13;  // holds a sum of up to 20 sign-extended bytes
  localparam int TIMEOUT_W   = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd25;

  typedef enum logic [1:0] {
    CMD_MESSAGE = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CAUSE_FIRST   = 2'd0,
    CAUSE_BAD_ACK = 2'd1,
    CAUSE_TIMEOUT = 2'd2
  } cause_t;

  // Classified item passed from front to back.
  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [BYTE_SUM_W-1:0] byte_sum;
    logic [CHECK_W-1:0]           seq_ack_sum;
    logic [CHECK_W-1:0]           check_in;
    logic                         ack_is_0;
    logic                         ack_is_1;
  } cmd_info_t;

  // Header of one packet to send.
  typedef struct packed {
    logic               seq_bit;
    logic [CHECK_W-1:0] check;
    logic [1:0]         cause;
  } send_info_t;

endpackage

>>> rtl/core/abs_fifo.sv
// Small register-based FIFO used between the stages.
module abs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/abs_front.sv
// Front stage: takes items, sums payload bytes and precomputes ack checks.
module abs_front #(
  parameter int STORED_BYTES = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           command,
  input  logic [abs_pkg::MAX_BYTES*8-1:0]      pay_in,
  input  logic signed [abs_pkg::CHECK_W-1:0]   seq_in,
  input  logic signed [abs_pkg::CHECK_W-1:0]   ack_in,
  input  logic signed [abs_pkg::CHECK_W-1:0]   check_in,
  output logic                                 q_push,
  input  logic                                 q_full,
  output abs_pkg::cmd_info_t                   q_info,
  output logic [STORED_BYTES*8-1:0]            q_pay
);

  localparam int PAY_W = STORED_BYTES * 8;
  localparam int GRPS  = (STORED_BYTES + 3) / 4;

  logic                                  valid;
  logic                                  take;
  abs_pkg::cmd_info_t                    info_next;
  logic signed [abs_pkg::BYTE_SUM_W-1:0] grp [GRPS];
  logic signed [abs_pkg::BYTE_SUM_W-1:0] byte_sum;

  assign full   = valid && q_full;
  assign take   = push && !full;
  assign q_push = valid;

  // Adder tree: groups of four bytes, then the group sums.
  always_comb begin
    int idx;
    idx = 0;
    for (int g = 0; g < GRPS; g++) begin
      grp[g] = '0;
      for (int k = 0; k < 4; k++) begin
        idx = g * 4 + k;
        if (idx < STORED_BYTES) begin
          grp[g] = grp[g] + abs_pkg::BYTE_SUM_W'(signed'(pay_in[idx*8 +: 8]));
        end
      end
    end
    byte_sum = '0;
    for (int g = 0; g < GRPS; g++) begin
      byte_sum = byte_sum + grp[g];
    end
  end

  always_comb begin
    info_next.cmd         = command;
    info_next.byte_sum    = byte_sum;
    info_next.seq_ack_sum = abs_pkg::CHECK_W'(seq_in + ack_in);
    info_next.check_in    = check_in;
    info_next.ack_is_0    = (ack_in == 32'sd0);
    info_next.ack_is_1    = (ack_in == 32'sd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (!q_full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_info <= info_next;
      q_pay  <= pay_in[PAY_W-1:0];
    end
  end

endmodule

>>> rtl/core/abs_back.sv
// Back stage: protocol state, stored packet, timer and packet sends.
module abs_back #(
  parameter int STORED_BYTES = 20,
  parameter int TIMER_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [abs_pkg::TIMEOUT_W-1:0]     cfg_data,
  input  logic                              q_empty,
  input  abs_pkg::cmd_info_t                q_info,
  input  logic [STORED_BYTES*8-1:0]         q_pay,
  output logic                              q_pop,
  input  logic                              r_full,
  output logic                              r_push,
  output abs_pkg::send_info_t               r_info,
  output logic [STORED_BYTES*8-1:0]         r_pay
);

  localparam int PAY_W = STORED_BYTES * 8;

  logic [abs_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic                          waiting;
  logic                          seq_bit;
  logic [TIMER_BITS-1:0]         ticks_left;
  logic [PAY_W-1:0]              stored_pay;
  logic [abs_pkg::CHECK_W-1:0]   stored_check;

  logic                          waiting_next;
  logic                          seq_bit_next;
  logic [TIMER_BITS-1:0]         ticks_left_next;
  logic                          store_en;
  logic [abs_pkg::CHECK_W-1:0]   msg_check;
  logic [abs_pkg::CHECK_W-1:0]   ack_calc;
  logic                          ack_good;
  logic                          fire;
  logic [TIMER_BITS-1:0]         arm_value;

  assign fire      = !q_empty && !r_full;
  assign q_pop     = fire;
  assign arm_value = TIMER_BITS'(timeout_ticks);
  assign msg_check = abs_pkg::CHECK_W'(q_info.byte_sum) + abs_pkg::CHECK_W'(seq_bit);
  assign ack_calc  = abs_pkg::CHECK_W'(q_info.byte_sum) + q_info.seq_ack_sum;
  assign ack_good  = (seq_bit ? q_info.ack_is_1 : q_info.ack_is_0)
                     && (ack_calc == q_info.check_in);

  always_comb begin
    waiting_next    = waiting;
    seq_bit_next    = seq_bit;
    ticks_left_next = ticks_left;
    store_en        = 1'b0;
    r_push          = 1'b0;
    r_info.seq_bit  = seq_bit;
    r_info.check    = stored_check;
    r_info.cause    = abs_pkg::CAUSE_FIRST;
    r_pay           = stored_pay;
    if (fire && waiting) begin
      case (abs_pkg::cmd_t'(q_info.cmd))
        abs_pkg::CMD_ACK: begin
          if (ack_good) begin
            ticks_left_next = '0;
            waiting_next    = 1'b0;
            seq_bit_next    = !seq_bit;
          end else begin
            r_push       = 1'b1;
            r_info.cause = abs_pkg::CAUSE_BAD_ACK;
          end
        end
        abs_pkg::CMD_TICK: begin
          // zero or one left: timeout fires
          if (ticks_left <= TIMER_BITS'(1)) begin
            ticks_left_next = arm_value;
            r_push          = 1'b1;
            r_info.cause    = abs_pkg::CAUSE_TIMEOUT;
          end else begin
            ticks_left_next = ticks_left - 1'b1;
          end
        end
        default: ;  // message or unused code while waiting is dropped
      endcase
    end else if (fire && (abs_pkg::cmd_t'(q_info.cmd) == abs_pkg::CMD_MESSAGE)) begin
      store_en        = 1'b1;
      waiting_next    = 1'b1;
      ticks_left_next = arm_value;
      r_push          = 1'b1;
      r_info.check    = msg_check;
      r_info.cause    = abs_pkg::CAUSE_FIRST;
      r_pay           = q_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= abs_pkg::TIMEOUT_RESET;
      waiting       <= 1'b0;
      seq_bit       <= 1'b0;
      ticks_left    <= '0;
    end else begin
      if (cfg_write) begin
        timeout_ticks <= cfg_data;
      end
      waiting    <= waiting_next;
      seq_bit    <= seq_bit_next;
      ticks_left <= ticks_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      stored_pay   <= q_pay;
      stored_check <= msg_check;
    end
  end

endmodule

>>> rtl/core/alternating_bit_sender_unit.sv
// Top level of the alternating-bit protocol sender.
//
// Channel   Direction  Handshake         Fields
// input     in         push / full       command, payload_low/mid/high,
//                                        in_seq_number, in_ack_number, in_check_value
// result    out        empty / pop       out_seq_bit, out_ack_number, out_check_value,
//                                        out_payload_low/mid/high, send_cause
// config    in         cfg_write         cfg_data (timeout_ticks)
//
// One item per cycle sustained while the result queue is not full; a packet send
// passes the front register and the item queue before the back stage
// writes the result queue directly.
// The front adder tree and the back's 32-bit adds and compare set the clock.
// rst is synchronous: sender idle, sequence bit 0, timer 0, timeout 25 ticks.
// A full result queue stalls the back stage, the item queue then fills and
// full rises; each side stalls on its own.
module alternating_bit_sender_unit #(
  parameter int PAYLOAD_BYTES = 20,
  parameter int TIMER_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic [63:0]        payload_low,
  input  logic [63:0]        payload_mid,
  input  logic [31:0]        payload_high,
  input  logic signed [31:0] in_seq_number,
  input  logic signed [31:0] in_ack_number,
  input  logic signed [31:0] in_check_value,
  output logic               empty,
  input  logic               pop,
  output logic               out_seq_bit,
  output logic               out_ack_number,
  output logic signed [31:0] out_check_value,
  output logic [63:0]        out_payload_low,
  output logic [63:0]        out_payload_mid,
  output logic [31:0]        out_payload_high,
  output logic [1:0]         send_cause,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data
);

  localparam int STORED_BYTES = (PAYLOAD_BYTES < abs_pkg::MAX_BYTES) ?
                                PAYLOAD_BYTES : abs_pkg::MAX_BYTES;
  localparam int PAY_W        = STORED_BYTES * 8;
  localparam int ITEM_W       = $bits(abs_pkg::cmd_info_t) + PAY_W;
  localparam int SEND_W       = $bits(abs_pkg::send_info_t) + PAY_W;
  localparam int ALL_W        = abs_pkg::MAX_BYTES * 8;

  logic [ALL_W-1:0]    pay_in;
  logic                f_push;
  logic                iq_full;
  abs_pkg::cmd_info_t  f_info;
  logic [PAY_W-1:0]    f_pay;
  logic [ITEM_W-1:0]   iq_dout;
  logic                iq_empty;
  logic                iq_pop;
  abs_pkg::cmd_info_t  b_info;
  logic [PAY_W-1:0]    b_pay;
  logic                rq_full;
  logic                r_push;
  abs_pkg::send_info_t r_info;
  logic [PAY_W-1:0]    r_pay;
  logic [SEND_W-1:0]   rq_dout;
  abs_pkg::send_info_t o_info;
  logic [ALL_W-1:0]    o_pay;

  assign pay_in = {payload_high, payload_mid, payload_low};

  abs_front #(.STORED_BYTES(STORED_BYTES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .command  (command),
    .pay_in   (pay_in),
    .seq_in   (in_seq_number),
    .ack_in   (in_ack_number),
    .check_in (in_check_value),
    .q_push   (f_push),
    .q_full   (iq_full),
    .q_info   (f_info),
    .q_pay    (f_pay)
  );

  abs_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   ({f_info, f_pay}),
    .full  (iq_full),
    .pop   (iq_pop),
    .dout  (iq_dout),
    .empty (iq_empty)
  );

  assign b_info = abs_pkg::cmd_info_t'(iq_dout[ITEM_W-1:PAY_W]);
  assign b_pay  = iq_dout[PAY_W-1:0];

  abs_back #(.STORED_BYTES(STORED_BYTES), .TIMER_BITS(TIMER_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_empty   (iq_empty),
    .q_info    (b_info),
    .q_pay     (b_pay),
    .q_pop     (iq_pop),
    .r_full    (rq_full),
    .r_push    (r_push),
    .r_info    (r_info),
    .r_pay     (r_pay)
  );

  abs_fifo #(.WIDTH(SEND_W), .DEPTH(2)) u_send_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   ({r_info, r_pay}),
    .full  (rq_full),
    .pop   (pop),
    .dout  (rq_dout),
    .empty (empty)
  );

  assign o_info = abs_pkg::send_info_t'(rq_dout[SEND_W-1:PAY_W]);
  assign o_pay  = ALL_W'(rq_dout[PAY_W-1:0]);

  assign out_seq_bit      = o_info.seq_bit;
  assign out_ack_number   = 1'b0;
  assign out_check_value  = signed'(o_info.check);
  assign out_payload_low  = o_pay[63:0];
  assign out_payload_mid  = o_pay[127:64];
  assign out_payload_high = o_pay[159:128];
  assign send_cause       = o_info.cause;

endmodule

>>> tb/tb_alternating_bit_sender_unit.sv
// Self-checking testbench for the alternating-bit protocol sender.
`timescale 1ns / 100ps

module tb_alternating_bit_sender_unit;

  localparam int LIMIT_CYCLES  = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {
    ACK_GOOD,
    ACK_WRONG_BIT,
    ACK_HIGH_BITS,
    ACK_BAD_CHECK
  } ack_flaw_t;

  typedef struct {
    logic [1:0]   cmd;
    logic [159:0] bytes;     // byte i at bits 8*i
    logic [31:0]  seq_num;
    logic [31:0]  ack_num;
    logic [31:0]  check;
  } cmd_item_t;

  typedef struct {
    logic             seq_bit;
    logic             ack_number;
    logic [31:0]      check;
    logic [159:0]     bytes;
    abs_pkg::cause_t  cause;
  } sent_packet_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         command = abs_pkg::CMD_TICK;
  logic [63:0]        payload_low = '0;
  logic [63:0]        payload_mid = '0;
  logic [31:0]        payload_high = '0;
  logic signed [31:0] in_seq_number = '0;
  logic signed [31:0] in_ack_number = '0;
  logic signed [31:0] in_check_value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               out_seq_bit;
  logic               out_ack_number;
  logic signed [31:0] out_check_value;
  logic [63:0]        out_payload_low;
  logic [63:0]        out_payload_mid;
  logic [31:0]        out_payload_high;
  logic [1:0]         send_cause;
  logic               cfg_write = 1'b0;
  logic [15:0]        cfg_data = '0;

  // sender model state
  logic         wait_ack_m = 1'b0;
  logic         seq_bit_m = 1'b0;
  logic [159:0] held_bytes = '0;
  logic [31:0]  held_check = '0;
  logic [15:0]  ticks_m = '0;
  logic [15:0]  timeout_m = abs_pkg::TIMEOUT_RESET;

  sent_packet_t pending_packets[$];
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int pop_hold_cycles = 0;

  alternating_bit_sender_unit dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .command          (command),
    .payload_low      (payload_low),
    .payload_mid      (payload_mid),
    .payload_high     (payload_high),
    .in_seq_number    (in_seq_number),
    .in_ack_number    (in_ack_number),
    .in_check_value   (in_check_value),
    .empty            (empty),
    .pop              (pop),
    .out_seq_bit      (out_seq_bit),
    .out_ack_number   (out_ack_number),
    .out_check_value  (out_check_value),
    .out_payload_low  (out_payload_low),
    .out_payload_mid  (out_payload_mid),
    .out_payload_high (out_payload_high),
    .send_cause       (send_cause),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] byte_sum(logic [159:0] b);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < 20; i++)
      s += {{24{b[8*i+7]}}, b[8*i +: 8]};
    return s;
  endfunction

  function automatic void queue_packet(abs_pkg::cause_t cause);
    sent_packet_t p;
    p.seq_bit    = seq_bit_m;
    p.ack_number = 1'b0;
    p.check      = held_check;
    p.bytes      = held_bytes;
    p.cause      = cause;
    pending_packets.push_back(p);
  endfunction

  function automatic void advance_sender(cmd_item_t it);
    logic [31:0] calc;
    case (it.cmd)
      abs_pkg::CMD_MESSAGE: if (!wait_ack_m) begin
        held_bytes = it.bytes;
        held_check = byte_sum(it.bytes) + {31'b0, seq_bit_m};
        wait_ack_m = 1'b1;
        ticks_m    = timeout_m;
        queue_packet(abs_pkg::CAUSE_FIRST);
      end
      abs_pkg::CMD_ACK: if (wait_ack_m) begin
        calc = byte_sum(it.bytes) + it.seq_num + it.ack_num;
        if (it.ack_num != {31'b0, seq_bit_m} || it.check != calc) begin
          queue_packet(abs_pkg::CAUSE_BAD_ACK);   // timer keeps running
        end else begin
          ticks_m    = '0;
          wait_ack_m = 1'b0;
          seq_bit_m  = ~seq_bit_m;
        end
      end
      abs_pkg::CMD_TICK: if (wait_ack_m) begin
        // zero and one both expire on this tick
        if (ticks_m <= 16'd1) begin
          ticks_m = timeout_m;
          queue_packet(abs_pkg::CAUSE_TIMEOUT);
        end else begin
          ticks_m = ticks_m - 16'd1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit takes_effect(cmd_item_t it);
    case (it.cmd) inside
      abs_pkg::CMD_MESSAGE:                   return !wait_ack_m;
      abs_pkg::CMD_ACK, abs_pkg::CMD_TICK:    return wait_ack_m;
      default:                                return 1'b0;
    endcase
  endfunction

  // ----------------------------------------------------------- item makers

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [159:0] random_bytes();
    logic [159:0] b;
    for (int i = 0; i < 20; i++) begin
      case ($urandom_range(0, 11))
        0:       b[8*i +: 8] = 8'h80;
        1:       b[8*i +: 8] = 8'h7F;
        2:       b[8*i +: 8] = 8'hFF;
        3:       b[8*i +: 8] = 8'h00;
        default: b[8*i +: 8] = 8'($urandom);
      endcase
    end
    return b;
  endfunction

  function automatic cmd_item_t plain_item(logic [1:0] cmd, logic [159:0] bytes);
    cmd_item_t it;
    it.cmd     = cmd;
    it.bytes   = bytes;
    it.seq_num = random_word();
    it.ack_num = random_word();
    it.check   = random_word();
    return it;
  endfunction

  // ack aimed at the current sequence bit, optionally spoiled one way
  function automatic cmd_item_t make_ack(ack_flaw_t flaw, logic [31:0] seq_num);
    cmd_item_t it;
    it.cmd     = abs_pkg::CMD_ACK;
    it.bytes   = random_bytes();
    it.seq_num = seq_num;
    it.ack_num = {31'b0, seq_bit_m};
    case (flaw)
      ACK_WRONG_BIT: it.ack_num[0] = ~seq_bit_m;
      ACK_HIGH_BITS: it.ack_num[31:1] = 31'($urandom) | (31'h1 << $urandom_range(0, 30));
      default: ;
    endcase
    it.check = byte_sum(it.bytes) + it.seq_num + it.ack_num;
    if (flaw == ACK_BAD_CHECK)
      it.check ^= 32'h1 << $urandom_range(0, 31);
    return it;
  endfunction

  function automatic cmd_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (!wait_ack_m) begin
      if (pick < 82) return plain_item(abs_pkg::CMD_MESSAGE, random_bytes());
      if (pick < 88) return make_ack(ACK_GOOD, random_word());
      if (pick < 94) return plain_item(abs_pkg::CMD_TICK, random_bytes());
      return plain_item(CMD_UNUSED, random_bytes());
    end
    if (pick < 45) return plain_item(abs_pkg::CMD_TICK, random_bytes());
    if (pick < 65) return make_ack(ACK_GOOD, random_word());
    if (pick < 80) return make_ack(ack_flaw_t'($urandom_range(1, 3)), random_word());
    if (pick < 92) return plain_item(abs_pkg::CMD_MESSAGE, random_bytes());
    return plain_item(CMD_UNUSED, random_bytes());
  endfunction

  // ------------------------------------------------------------- drivers

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input cmd_item_t it);
    command        = it.cmd;
    payload_low    = it.bytes[63:0];
    payload_mid    = it.bytes[127:64];
    payload_high   = it.bytes[159:128];
    in_seq_number  = it.seq_num;
    in_ack_number  = it.ack_num;
    in_check_value = it.check;
    push           = 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    advance_sender(it);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // wait out every expected packet plus the pipeline of silent items
  task automatic settle();
    push = 1'b0;
    while (pending_packets.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] ticks);
    settle();
    cfg_write = 1'b1;
    cfg_data  = ticks;
    @(negedge clk);
    cfg_write = 1'b0;
    timeout_m = ticks;
  endtask

  // receiver: stretches of differing pop density, plus requested hold-offs
  initial begin
    int mode, span, hold;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk);
        if (pop_hold_cycles > 0) begin
          hold = pop_hold_cycles;
          pop_hold_cycles = 0;
          pop = 1'b0;
          repeat (hold) @(negedge clk);
        end
        case (mode)
          0:       pop = 1'b1;
          1:       pop = 1'($urandom_range(0, 1));
          2:       pop = ($urandom_range(0, 3) == 0);
          default: pop = ($urandom_range(0, 5) != 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------- checking

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%s", msg);
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got)
      note_mismatch($sformatf("%s mismatch: expected %h, got %h", name, want, got));
  endfunction

  always @(posedge clk) begin
    sent_packet_t got, want;
    if (!rst && !empty && pop) begin
      got.seq_bit    = out_seq_bit;
      got.ack_number = out_ack_number;
      got.check      = out_check_value;
      got.bytes      = {out_payload_high, out_payload_mid, out_payload_low};
      got.cause      = abs_pkg::cause_t'(send_cause);
      if (pending_packets.size() == 0) begin
        note_mismatch($sformatf("packet sent with none expected, cause %0d", send_cause));
      end else begin
        want = pending_packets.pop_front();
        compare_field("out_seq_bit", 64'(want.seq_bit), 64'(got.seq_bit));
        compare_field("out_ack_number", 64'(want.ack_number), 64'(got.ack_number));
        compare_field("out_check_value", 64'(want.check), 64'(got.check));
        compare_field("out_payload_low", want.bytes[63:0], got.bytes[63:0]);
        compare_field("out_payload_mid", want.bytes[127:64], got.bytes[127:64]);
        compare_field("out_payload_high", 64'(want.bytes[159:128]),
                      64'(got.bytes[159:128]));
        compare_field("send_cause", 64'(want.cause), 64'(got.cause));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // acks, ticks and the unused code are all ignored while idle
  task automatic test_idle_commands();
    send_item(make_ack(ACK_GOOD, random_word()));
    send_item(plain_item(abs_pkg::CMD_TICK, random_bytes()));
    send_item(plain_item(CMD_UNUSED, random_bytes()));
  endtask

  task automatic test_handshake_cycle();
    send_item(plain_item(abs_pkg::CMD_MESSAGE, {20{8'hFF}}));
    send_item(make_ack(ACK_HIGH_BITS, random_word()));
    send_item(make_ack(ACK_BAD_CHECK, random_word()));
    send_item(plain_item(abs_pkg::CMD_MESSAGE, random_bytes()));  // dropped while waiting
    send_item(make_ack(ACK_GOOD, 32'h7FFF_FFFF));
    send_item(plain_item(abs_pkg::CMD_MESSAGE, {20{8'h80}}));
    send_item(make_ack(ACK_WRONG_BIT, random_word()));
    send_item(make_ack(ACK_GOOD, 32'h8000_0000));
    send_item(plain_item(abs_pkg::CMD_MESSAGE, {20{8'h7F}}));
    send_item(make_ack(ACK_GOOD, 32'hFFFF_FFFF));
    send_item(plain_item(abs_pkg::CMD_MESSAGE, '0));
    send_item(make_ack(ACK_GOOD, 32'h0));
  endtask

  task automatic test_timer_expiry();
    set_timeout(16'd1);
    send_item(plain_item(abs_pkg::CMD_MESSAGE, random_bytes()));
    send_item(plain_item(abs_pkg::CMD_TICK, random_bytes()));
    send_item(make_ack(ACK_GOOD, random_word()));
    set_timeout(16'd3);
    send_item(plain_item(abs_pkg::CMD_MESSAGE, random_bytes()));
    repeat (3) send_item(plain_item(abs_pkg::CMD_TICK, random_bytes()));
    send_item(make_ack(ACK_GOOD, random_word()));
  endtask

  task automatic test_zero_timeout();
    set_timeout(16'd0);
    send_item(plain_item(abs_pkg::CMD_MESSAGE, random_bytes()));
    send_item(plain_item(abs_pkg::CMD_TICK, random_bytes()));
    send_item(make_ack(ACK_GOOD, random_word()));
  endtask

  // receiver holds off while bad acks pile up resends until full rises
  task automatic test_backpressure();
    settle();
    if (wait_ack_m)
      send_item(make_ack(ACK_GOOD, random_word()));
    send_item(plain_item(abs_pkg::CMD_MESSAGE, random_bytes()));
    pop_hold_cycles = 300;
    repeat (64) send_item(make_ack(ack_flaw_t'($urandom_range(1, 3)), random_word()));
    send_item(make_ack(ACK_GOOD, random_word()));
  endtask

  task automatic test_random_traffic(input logic [15:0] ticks, input int count);
    cmd_item_t it;
    int done;
    set_timeout(ticks);
    done = 0;
    while (done < count) begin
      it = random_item();
      if (takes_effect(it))
        done++;
      send_item(it);
      pace_sender();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_commands();
    test_handshake_cycle();
    test_timer_expiry();
    test_zero_timeout();
    test_backpressure();
    test_random_traffic(16'd2, 170);
    test_random_traffic(16'd5, 170);
    test_random_traffic(16'd1, 170);
    test_random_traffic(16'd40, 170);
    test_random_traffic(16'hFFFF, 170);
    test_random_traffic(16'($urandom_range(1, 12)), 170);
    test_random_traffic(16'd3, 170);

    settle();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_packets.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
